FILE: design/tbpl_pkg.sv
`default_nettype none

package tbpl_pkg;

   // Default widths of the time base and of the byte counters.
   localparam int TIME_BITS_DEFAULT  = 48;
   localparam int COUNT_BITS_DEFAULT = 40;

   // Fixed field widths.
   localparam int LEN_BITS      = 16;
   localparam int RATE_BITS     = 32;
   localparam int WAIT_BITS     = 20;
   localparam int MEAS_BITS     = 40;
   localparam int VERDICT_BITS  = 2;
   localparam int ELAPSED_BITS  = 18;
   localparam int MUL_B_BITS    = 20;
   localparam int TOKEN_BITS    = RATE_BITS + MUL_B_BITS;
   localparam int COST_BITS     = 36;
   localparam int DIVIDEND_BITS = COST_BITS + 1;
   localparam int DIV_COUNT_BITS = $clog2(WAIT_BITS);
   localparam int RSP_DATA_BITS =
      ((VERDICT_BITS + WAIT_BITS + MEAS_BITS + 7) / 8) * 8;

   // Time and size constants.
   localparam logic [ELAPSED_BITS-1:0] ELAPSED_CAP_US = 18'd200000;
   localparam logic [MUL_B_BITS-1:0]   WINDOW_US      = 20'd1000000;
   localparam logic [MUL_B_BITS-1:0]   HALF_SECOND_US = 20'd500000;
   localparam logic [MUL_B_BITS-1:0]   ONE_SECOND_US  = 20'd1000000;
   localparam logic [LEN_BITS-1:0]     SMALL_PACKET   = 16'd100;
   localparam logic [MEAS_BITS-1:0]    MEAS_MAX       = {MEAS_BITS{1'b1}};

   // Register indexes of the configuration port.
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TRAFFIC_INBOUND = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LIMIT_ENABLE    = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RATE_LIMIT      = 2'd2;

   typedef enum logic [VERDICT_BITS-1:0] {
      VERDICT_PASS = 2'd0,
      VERDICT_WAIT = 2'd1,
      VERDICT_DROP = 2'd2
   } verdict_type;

   typedef enum logic [2:0] {
      MUL_NONE   = 3'd0,
      MUL_CAP    = 3'd1,
      MUL_COST   = 3'd2,
      MUL_REFILL = 3'd3,
      MUL_RSEC   = 3'd4
   } mul_op_type;

   typedef enum logic [2:0] {
      BKT_HOLD   = 3'd0,
      BKT_CLEAR  = 3'd1,
      BKT_INIT   = 3'd2,
      BKT_REFILL = 3'd3,
      BKT_SPEND  = 3'd4
   } bucket_op_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic          accept;
      logic          elapsed_step;
      mul_op_type    mul_op;
      bucket_op_type bucket_op;
      logic          applied_set;
      logic          applied_clear;
      logic          need_load;
      logic          div_start;
      logic          div_step;
      logic          late_load;
      logic          verdict_we;
      verdict_type   verdict;
      logic          out_load;
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic active;
      logic applied;
      logic bypass;
      logic fits;
      logic over_limit;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

FILE: design/token_bucket_packet_limiter_top.sv
// Channel  Dir  Handshake              Payload
// req      in   req_tvalid/req_tready  tdata: timestamp_us, packet_length; tuser: in_window
// rsp      out  rsp_tvalid/rsp_tready  tdata: verdict, wait_us, measured_rate; tuser: rate_update
// csr      in   csr_we                 csr_index, csr_wdata (no read-back)
//
// A result loads after the decision when limiting is off or bypassed, after the spend on a
// pass on credit, after the check on a drop and after the 20-step restoring divider on a wait;
// the next word is taken only once the result has loaded, so a word occupies the block alone.
// Reset is synchronous and active high; it restores the defaults and clears the persistent state.
// A new word is taken while the previous result waits on a stalled rsp side;
// the finished result then holds until the result register frees up.
`default_nettype none

module token_bucket_packet_limiter_top #(
   parameter int TIME_BITS  = tbpl_pkg::TIME_BITS_DEFAULT,
   parameter int COUNT_BITS = tbpl_pkg::COUNT_BITS_DEFAULT,
   localparam int REQ_DATA_BITS = ((TIME_BITS + tbpl_pkg::LEN_BITS + 7) / 8) * 8
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Input words.
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // From bit 0: timestamp_us (TIME_BITS), packet_length (16), zero fill.
   input  wire logic [REQ_DATA_BITS-1:0]            req_tdata,
   // Bit 0: in_window.
   input  wire logic                                req_tuser,
   // Result words.
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // From bit 0: verdict (2), wait_us (20), measured_rate (40), zero fill.
   output logic [tbpl_pkg::RSP_DATA_BITS-1:0]       rsp_tdata,
   // Bit 0: rate_update.
   output logic                                     rsp_tuser,
   // Register writes: 0 traffic_inbound, 1 limit_enable, 2 rate_limit.
   input  wire logic                                csr_we,
   input  wire logic [tbpl_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [tbpl_pkg::RATE_BITS-1:0]      csr_wdata
);

   // The controller steps each word through elapsed-time update, bucket
   // setup, refill, spend, and the optional divide; the datapath holds the
   // configuration and bucket state, the shared multiplier, the divider and the result register.
   tbpl_pkg::ctl_cmd_type   cmd;
   tbpl_pkg::dp_status_type sts;

   tbpl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   tbpl_datapath #(
      .TIME_BITS  (TIME_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

endmodule

`default_nettype wire

FILE: design/tbpl_ctrl.sv
`default_nettype none

module tbpl_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire tbpl_pkg::dp_status_type sts,
   output tbpl_pkg::ctl_cmd_type        cmd
);

   typedef enum logic [9:0] {
      ST_IDLE       = 10'b00_0000_0001,
      ST_ELAPSED    = 10'b00_0000_0010,
      ST_DECIDE     = 10'b00_0000_0100,
      ST_MUL_REFILL = 10'b00_0000_1000,
      ST_REFILL     = 10'b00_0001_0000,
      ST_SPEND      = 10'b00_0010_0000,
      ST_CHECK      = 10'b00_0100_0000,
      ST_DIV        = 10'b00_1000_0000,
      ST_LATE       = 10'b01_0000_0000,
      ST_OUT        = 10'b10_0000_0000
   } state_type;

   localparam logic [tbpl_pkg::DIV_COUNT_BITS-1:0] DIV_LAST =
      tbpl_pkg::DIV_COUNT_BITS'(tbpl_pkg::WAIT_BITS - 1);

   state_type                             state_ff, state_in;
   logic [tbpl_pkg::DIV_COUNT_BITS-1:0]   count_ff, count_in;

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = ST_ELAPSED;
            end
         end
         ST_ELAPSED: begin
            cmd.elapsed_step = 1'b1;
            cmd.mul_op       = tbpl_pkg::MUL_CAP;
            state_in         = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.mul_op = tbpl_pkg::MUL_COST;
            priority if (!sts.active) begin
               cmd.bucket_op     = tbpl_pkg::BKT_CLEAR;
               cmd.applied_clear = 1'b1;
               state_in          = ST_OUT;
            end else begin
               if (!sts.applied) begin
                  cmd.bucket_op   = tbpl_pkg::BKT_INIT;
                  cmd.applied_set = 1'b1;
               end
               state_in = sts.bypass ? ST_OUT : ST_MUL_REFILL;
            end
         end
         ST_MUL_REFILL: begin
            cmd.mul_op = tbpl_pkg::MUL_REFILL;
            state_in   = ST_REFILL;
         end
         ST_REFILL: begin
            cmd.bucket_op = tbpl_pkg::BKT_REFILL;
            cmd.mul_op    = tbpl_pkg::MUL_RSEC;
            state_in      = ST_SPEND;
         end
         ST_SPEND: begin
            priority if (sts.fits) begin
               cmd.bucket_op = tbpl_pkg::BKT_SPEND;
               state_in      = ST_OUT;
            end else begin
               cmd.bucket_op = tbpl_pkg::BKT_CLEAR;
               cmd.need_load = 1'b1;
               state_in      = ST_CHECK;
            end
         end
         ST_CHECK: begin
            priority if (sts.over_limit) begin
               cmd.verdict_we = 1'b1;
               cmd.verdict    = tbpl_pkg::VERDICT_DROP;
               state_in       = ST_OUT;
            end else begin
               cmd.div_start = 1'b1;
               count_in      = '0;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            count_in     = count_ff + tbpl_pkg::DIV_COUNT_BITS'(1);
            if (count_ff == DIV_LAST) begin
               state_in = ST_LATE;
            end
         end
         ST_LATE: begin
            cmd.late_load  = 1'b1;
            cmd.verdict_we = 1'b1;
            cmd.verdict    = tbpl_pkg::VERDICT_WAIT;
            state_in       = ST_OUT;
         end
         ST_OUT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // A result is never written over one that has not been taken.
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> sts.out_free)
      else $error("result register overwritten");

   // The divider always runs its full count before the late update.
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LATE) |-> ($past(count_ff) == DIV_LAST))
      else $error("divider left early");

endmodule

`default_nettype wire

FILE: design/tbpl_datapath.sv
`default_nettype none

module tbpl_datapath #(
   parameter int TIME_BITS  = tbpl_pkg::TIME_BITS_DEFAULT,
   parameter int COUNT_BITS = tbpl_pkg::COUNT_BITS_DEFAULT,
   localparam int REQ_DATA_BITS = ((TIME_BITS + tbpl_pkg::LEN_BITS + 7) / 8) * 8
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire tbpl_pkg::ctl_cmd_type                 cmd,
   output tbpl_pkg::dp_status_type                    sts,
   input  wire logic [REQ_DATA_BITS-1:0]              req_tdata,
   input  wire logic                                  req_tuser,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   output logic [tbpl_pkg::RSP_DATA_BITS-1:0]         rsp_tdata,
   output logic                                       rsp_tuser,
   input  wire logic                                  csr_we,
   input  wire logic [tbpl_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [tbpl_pkg::RATE_BITS-1:0]        csr_wdata
);

   localparam int LB = tbpl_pkg::LEN_BITS;
   localparam int RB = tbpl_pkg::RATE_BITS;
   localparam int WB = tbpl_pkg::WAIT_BITS;
   localparam int KB = tbpl_pkg::TOKEN_BITS;
   localparam int CB = tbpl_pkg::COST_BITS;
   localparam int DB = tbpl_pkg::DIVIDEND_BITS;
   localparam int EB = tbpl_pkg::ELAPSED_BITS;
   localparam int MB = tbpl_pkg::MEAS_BITS;
   localparam int PAD_BITS =
      tbpl_pkg::RSP_DATA_BITS - tbpl_pkg::VERDICT_BITS - WB - MB;

   // Configuration.
   logic                  inbound_ff, inbound_in;
   logic                  enable_ff, enable_in;
   logic [RB-1:0]         rate_ff, rate_in;
   // Persistent state.
   logic                  applied_ff, applied_in;
   logic [TIME_BITS-1:0]  last_time_ff, last_time_in;
   logic [TIME_BITS-1:0]  window_start_ff, window_start_in;
   logic [COUNT_BITS-1:0] window_bytes_ff, window_bytes_in;
   logic [COUNT_BITS-1:0] rate_hold_ff, rate_hold_in;
   logic [KB-1:0]         bucket_ff, bucket_in;
   // Per-packet working registers.
   logic [TIME_BITS-1:0]  ts_ff, ts_in;
   logic [LB-1:0]         len_ff, len_in;
   logic                  window_flag_ff, window_flag_in;
   logic [EB-1:0]         elapsed_ff, elapsed_in;
   logic [KB-1:0]         cap_ff, cap_in;
   logic [CB-1:0]         cost_ff, cost_in;
   logic [KB-1:0]         refill_ff, refill_in;
   logic [KB-1:0]         rsec_ff, rsec_in;
   logic [CB-1:0]         need_ff, need_in;
   logic [RB-1:0]         rem_ff, rem_in;
   logic [WB-1:0]         quot_ff, quot_in;
   tbpl_pkg::verdict_type verdict_ff, verdict_in;
   logic                  update_ff, update_in;
   // Result register.
   logic                  rsp_valid_ff, rsp_valid_in;
   tbpl_pkg::verdict_type rsp_verdict_ff, rsp_verdict_in;
   logic [WB-1:0]         rsp_wait_ff, rsp_wait_in;
   logic [MB-1:0]         rsp_meas_ff, rsp_meas_in;
   logic                  rsp_update_ff, rsp_update_in;

   // Combinational helpers.
   logic [RB-1:0]         mul_a;
   logic [tbpl_pkg::MUL_B_BITS-1:0] mul_b;
   logic [KB-1:0]         product;
   logic [TIME_BITS-1:0]  time_diff;
   logic [TIME_BITS-1:0]  win_diff;
   logic [COUNT_BITS:0]   byte_sum;
   logic [COUNT_BITS-1:0] byte_sat;
   logic [KB:0]           bucket_sum;
   logic [DB-1:0]         dividend;
   logic [RB:0]           trial;

   // One shared multiplier; the product of each selected operation lands in a register.
   always_comb begin
      unique case (cmd.mul_op)
         tbpl_pkg::MUL_CAP: begin
            mul_a = rate_ff;
            mul_b = tbpl_pkg::HALF_SECOND_US;
         end
         tbpl_pkg::MUL_COST: begin
            mul_a = RB'(len_ff);
            mul_b = tbpl_pkg::ONE_SECOND_US;
         end
         tbpl_pkg::MUL_REFILL: begin
            mul_a = rate_ff;
            mul_b = tbpl_pkg::MUL_B_BITS'(elapsed_ff);
         end
         tbpl_pkg::MUL_RSEC: begin
            mul_a = rate_ff;
            mul_b = tbpl_pkg::ONE_SECOND_US;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      product = KB'(mul_a) * KB'(mul_b);
   end

   always_comb begin
      time_diff  = ts_ff - last_time_ff;
      win_diff   = ts_ff - window_start_ff;
      byte_sum   = {1'b0, window_bytes_ff} + (COUNT_BITS + 1)'(len_ff);
      byte_sat   = byte_sum[COUNT_BITS] ? '1 : byte_sum[COUNT_BITS-1:0];
      bucket_sum = {1'b0, bucket_ff} + {1'b0, refill_ff};
      dividend   = {1'b0, need_ff} + DB'(rate_ff) - DB'(1);
      trial      = {rem_ff, quot_ff[WB-1]} - {1'b0, rate_ff};
   end

   always_comb begin
      inbound_in      = inbound_ff;
      enable_in       = enable_ff;
      rate_in         = rate_ff;
      applied_in      = applied_ff;
      last_time_in    = last_time_ff;
      window_start_in = window_start_ff;
      window_bytes_in = window_bytes_ff;
      rate_hold_in    = rate_hold_ff;
      bucket_in       = bucket_ff;
      ts_in           = ts_ff;
      len_in          = len_ff;
      window_flag_in  = window_flag_ff;
      elapsed_in      = elapsed_ff;
      cap_in          = cap_ff;
      cost_in         = cost_ff;
      refill_in       = refill_ff;
      rsec_in         = rsec_ff;
      need_in         = need_ff;
      rem_in          = rem_ff;
      quot_in         = quot_ff;
      verdict_in      = verdict_ff;
      update_in       = update_ff;
      rsp_verdict_in  = rsp_verdict_ff;
      rsp_wait_in     = rsp_wait_ff;
      rsp_meas_in     = rsp_meas_ff;
      rsp_update_in   = rsp_update_ff;
      rsp_valid_in    = rsp_valid_ff & ~rsp_tready;

      if (cmd.accept) begin
         ts_in          = req_tdata[TIME_BITS-1:0];
         len_in         = req_tdata[TIME_BITS +: LB];
         window_flag_in = req_tuser;
         verdict_in     = tbpl_pkg::VERDICT_PASS;
         update_in      = 1'b0;
      end

      // Elapsed time, clamped, and the one-second byte window.
      if (cmd.elapsed_step) begin
         elapsed_in   = (time_diff > TIME_BITS'(tbpl_pkg::ELAPSED_CAP_US))
                        ? tbpl_pkg::ELAPSED_CAP_US : time_diff[EB-1:0];
         last_time_in = ts_ff;
         if (win_diff >= TIME_BITS'(tbpl_pkg::WINDOW_US)) begin
            rate_hold_in    = byte_sat;
            window_bytes_in = '0;
            window_start_in = ts_ff;
            update_in       = 1'b1;
         end else begin
            window_bytes_in = byte_sat;
         end
      end

      unique case (cmd.mul_op)
         tbpl_pkg::MUL_CAP:    cap_in    = product;
         tbpl_pkg::MUL_COST:   cost_in   = product[CB-1:0];
         tbpl_pkg::MUL_REFILL: refill_in = product;
         tbpl_pkg::MUL_RSEC:   rsec_in   = product;
         default: begin
         end
      endcase

      unique case (cmd.bucket_op)
         tbpl_pkg::BKT_CLEAR:  bucket_in = '0;
         tbpl_pkg::BKT_INIT:   bucket_in = cap_ff;
         tbpl_pkg::BKT_REFILL: bucket_in = (bucket_sum > {1'b0, cap_ff})
                                           ? cap_ff : bucket_sum[KB-1:0];
         tbpl_pkg::BKT_SPEND:  bucket_in = bucket_ff - KB'(cost_ff);
         default: begin
         end
      endcase

      if (cmd.applied_set) begin
         applied_in = 1'b1;
      end
      if (cmd.applied_clear) begin
         applied_in = 1'b0;
      end

      // The bucket is below the cost here, so the shortfall fits the cost width.
      if (cmd.need_load) begin
         need_in = cost_ff - bucket_ff[CB-1:0];
      end

      // Ceiling division by dividing need + rate - 1; the quotient fits WAIT_BITS,
      // so the top part of the dividend already sits below the rate.
      if (cmd.div_start) begin
         rem_in  = RB'(dividend[DB-1:WB]);
         quot_in = dividend[WB-1:0];
      end
      if (cmd.div_step) begin
         if (!trial[RB]) begin
            rem_in  = trial[RB-1:0];
            quot_in = {quot_ff[WB-2:0], 1'b1};
         end else begin
            rem_in  = {rem_ff[RB-2:0], quot_ff[WB-1]};
            quot_in = {quot_ff[WB-2:0], 1'b0};
         end
      end

      // The time base moves past the wait.
      if (cmd.late_load) begin
         last_time_in = ts_ff + TIME_BITS'(quot_ff);
      end

      if (cmd.verdict_we) begin
         verdict_in = cmd.verdict;
      end

      if (cmd.out_load) begin
         rsp_valid_in   = 1'b1;
         rsp_verdict_in = verdict_ff;
         rsp_wait_in    = (verdict_ff == tbpl_pkg::VERDICT_WAIT) ? quot_ff : '0;
         rsp_meas_in    = (64'(rate_hold_ff) > 64'(tbpl_pkg::MEAS_MAX))
                          ? tbpl_pkg::MEAS_MAX : MB'(rate_hold_ff);
         rsp_update_in  = update_ff;
      end

      if (csr_we) begin
         unique case (csr_index)
            tbpl_pkg::CSR_TRAFFIC_INBOUND: inbound_in = csr_wdata[0];
            tbpl_pkg::CSR_LIMIT_ENABLE:    enable_in  = csr_wdata[0];
            tbpl_pkg::CSR_RATE_LIMIT: begin
               rate_in    = csr_wdata;
               applied_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inbound_ff      <= 1'b1;
         enable_ff       <= 1'b0;
         rate_ff         <= '0;
         applied_ff      <= 1'b0;
         last_time_ff    <= '0;
         window_start_ff <= '0;
         window_bytes_ff <= '0;
         rate_hold_ff    <= '0;
         bucket_ff       <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         inbound_ff      <= inbound_in;
         enable_ff       <= enable_in;
         rate_ff         <= rate_in;
         applied_ff      <= applied_in;
         last_time_ff    <= last_time_in;
         window_start_ff <= window_start_in;
         window_bytes_ff <= window_bytes_in;
         rate_hold_ff    <= rate_hold_in;
         bucket_ff       <= bucket_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ts_ff          <= ts_in;
      len_ff         <= len_in;
      window_flag_ff <= window_flag_in;
      elapsed_ff     <= elapsed_in;
      cap_ff         <= cap_in;
      cost_ff        <= cost_in;
      refill_ff      <= refill_in;
      rsec_ff        <= rsec_in;
      need_ff        <= need_in;
      rem_ff         <= rem_in;
      quot_ff        <= quot_in;
      verdict_ff     <= verdict_in;
      update_ff      <= update_in;
      rsp_verdict_ff <= rsp_verdict_in;
      rsp_wait_ff    <= rsp_wait_in;
      rsp_meas_ff    <= rsp_meas_in;
      rsp_update_ff  <= rsp_update_in;
   end

   always_comb begin
      sts.active     = enable_ff & window_flag_ff;
      sts.applied    = applied_ff;
      sts.bypass     = (rate_ff == '0) ||
                       (!inbound_ff && (len_ff < tbpl_pkg::SMALL_PACKET));
      sts.fits       = bucket_ff >= KB'(cost_ff);
      sts.over_limit = KB'(need_ff) > rsec_ff;
      sts.out_free   = ~rsp_valid_ff | rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_BITS{1'b0}}, rsp_meas_ff, rsp_wait_ff, rsp_verdict_ff};
   assign rsp_tuser  = rsp_update_ff;

   // A refill never leaves more than half a second of credit.
   a_refill_cap: assert property (@(posedge clock) disable iff (reset)
      (cmd.bucket_op == tbpl_pkg::BKT_REFILL) |=> (bucket_ff <= cap_ff))
      else $error("bucket above cap after refill");

   // The computed wait never exceeds one second.
   a_wait_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.late_load |-> (quot_ff <= tbpl_pkg::ONE_SECOND_US))
      else $error("wait above one second");

   // Only a delayed pass carries a wait.
   a_wait_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_verdict_ff != tbpl_pkg::VERDICT_WAIT))
      |-> (rsp_wait_ff == '0))
      else $error("wait given without wait verdict");

endmodule

`default_nettype wire
